// ===== sv/hdf_pkg.sv =====
`default_nettype none
package hdf_pkg;

    localparam logic [1:0] SEG_RST  = 2'd0;
    localparam logic [1:0] SEG_COL  = 2'd1;
    localparam logic [1:0] SEG_SP   = 2'd2;
    localparam logic [1:0] SEG_BODY = 2'd3;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_WHITE  = 3'd1;
    localparam logic [2:0] CLS_GREEN  = 3'd2;
    localparam logic [2:0] CLS_YELLOW = 3'd3;
    localparam logic [2:0] CLS_BLUE   = 3'd4;
    localparam logic [2:0] CLS_RED    = 3'd5;

    localparam logic [1:0] MODE_HEX   = 2'd0;
    localparam logic [1:0] MODE_MIXED = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;

    localparam logic CFG_COLOR = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_FF    = 8'hff;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        BK_HEX,
        BK_CHAR,
        BK_UNDER,
        BK_HEXCRLF,
        BK_UNDER2,
        BK_CHAR2
    } t_body;

    typedef struct packed {
        logic       rst;
        logic       col;
        logic [2:0] cls;
        logic       space;
        t_body      body;
        logic [7:0] data;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + {4'h0, n};
        return 8'h57 + {4'h0, n};
    endfunction

    function automatic logic [7:0] color_digit(input logic [2:0] cls);
        logic [7:0] d;
        unique case (cls)
            CLS_WHITE:  d = 8'h37;
            CLS_GREEN:  d = 8'h32;
            CLS_YELLOW: d = 8'h33;
            CLS_BLUE:   d = 8'h34;
            default:    d = 8'h31;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] seg_len(input t_desc d, input logic [1:0] seg);
        logic [2:0] n;
        unique case (seg)
            SEG_RST: n = d.rst ? 3'd4 : 3'd0;
            SEG_COL: n = d.col ? 3'd5 : 3'd0;
            SEG_SP:  n = d.space ? 3'd1 : 3'd0;
            default: begin
                unique case (d.body)
                    BK_CHAR, BK_UNDER: n = 3'd1;
                    BK_HEXCRLF:        n = 3'd5;
                    default:           n = 3'd3;
                endcase
            end
        endcase
        return n;
    endfunction

    // first segment at or after start that has bytes; body is never empty
    function automatic logic [1:0] first_seg(input t_desc d, input logic [1:0] start);
        logic [1:0] s;
        priority if (start <= SEG_RST && d.rst) s = SEG_RST;
        else if (start <= SEG_COL && d.col) s = SEG_COL;
        else if (start <= SEG_SP && d.space) s = SEG_SP;
        else s = SEG_BODY;
        return s;
    endfunction

    function automatic logic [7:0] seg_byte(input t_desc d, input logic [1:0] seg,
                                            input logic [2:0] idx);
        logic [7:0] c;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_char(d.data[7:4]);
        lo = hex_char(d.data[3:0]);
        c  = CH_SPACE;
        unique case (seg)
            SEG_RST: begin
                unique case (idx)
                    3'd0:    c = CH_ESC;
                    3'd1:    c = CH_LBR;
                    3'd2:    c = CH_ZERO;
                    default: c = CH_M;
                endcase
            end
            SEG_COL: begin
                unique case (idx)
                    3'd0:    c = CH_ESC;
                    3'd1:    c = CH_LBR;
                    3'd2:    c = CH_THREE;
                    3'd3:    c = color_digit(d.cls);
                    default: c = CH_M;
                endcase
            end
            SEG_SP: c = CH_SPACE;
            default: begin
                unique case (d.body)
                    BK_CHAR:  c = d.data;
                    BK_UNDER: c = CH_UNDER;
                    BK_UNDER2: c = (idx == 3'd2) ? CH_SPACE : CH_UNDER;
                    BK_CHAR2: c = (idx == 3'd0) ? d.data : CH_SPACE;
                    BK_HEXCRLF: begin
                        unique case (idx)
                            3'd0:    c = hi;
                            3'd1:    c = lo;
                            3'd2:    c = CH_SPACE;
                            3'd3:    c = CH_CR;
                            default: c = CH_LF;
                        endcase
                    end
                    default: begin
                        unique case (idx)
                            3'd0:    c = hi;
                            3'd1:    c = lo;
                            default: c = CH_SPACE;
                        endcase
                    end
                endcase
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hdf_in_if.sv =====
`default_nettype none
interface hdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/hdf_out_if.sv =====
`default_nettype none
interface hdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/hex_dump_byte_formatter.sv =====
// channel  | dir | payload                         | handshake
// i_in     | in  | data_byte[7:0]                  | valid / ready
// o_out    | out | out_char[7:0], last_of_run      | valid / ready
// cfg      | in  | i_cfg_idx, i_cfg_data[1:0]      | i_cfg_we
//
// Each item yields 1 to 14 output bytes, one per cycle from the output register
// while the output is not stalled; a plain hex byte gives 3.
// The front classifies an item in its accept cycle and queues it; the back
// pops the next queued item in the cycle that issues the current one's last byte.
// Output stalls back up through the queue; input is taken while the queue has room.
// Reset clears state, config and queue.
`default_nettype none
module hex_dump_byte_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hdf_in_if.sink          i_in,
    hdf_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [1:0] i_cfg_data
);
    import hdf_pkg::*;

    t_q_push q_push;
    t_q_stat q_stat;
    t_desc   q_desc;
    logic    q_pop;

    hdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stat     (q_stat),
        .o_push     (q_push)
    );

    hdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_desc  (q_desc),
        .o_stat  (q_stat)
    );

    hdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (q_desc),
        .i_stat  (q_stat),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.nonempty)
        else $error("queue read while empty");

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> q_stat.nonempty)
        else $error("accepted item not queued");
endmodule
`default_nettype wire

// ===== sv/hdf_front.sv =====
`default_nettype none
module hdf_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    hdf_in_if.sink                i_in,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [1:0]       i_cfg_data,
    input  wire hdf_pkg::t_q_stat i_stat,
    output hdf_pkg::t_q_push      o_push
);
    import hdf_pkg::*;

    logic       r_color_en;
    logic [1:0] r_mode;
    logic [7:0] r_prior_byte;
    logic [2:0] r_prior_class;

    logic       accept;
    logic [7:0] b;
    logic       is_print;
    logic       was_print;
    logic       graphic;
    logic [2:0] cls;
    logic       col_chg;
    t_desc      desc;

    assign i_in.ready = !i_stat.full;
    assign accept     = i_in.valid && !i_stat.full;
    assign b          = i_in.data_byte;

    always_comb begin
        is_print  = (b >= CH_SPACE) && (b < CH_DEL);
        was_print = (r_prior_byte >= CH_SPACE) && (r_prior_byte < CH_DEL);
        graphic   = (b > CH_SPACE) && (b < CH_DEL);

        priority if (b == CH_SPACE || b == CH_NUL) cls = CLS_WHITE;
        else if (graphic) cls = CLS_GREEN;
        else if (b == CH_TAB || b == CH_LF || b == CH_CR) cls = CLS_YELLOW;
        else if (b == CH_FF) cls = CLS_BLUE;
        else cls = CLS_RED;

        col_chg    = r_color_en && (cls != r_prior_class);
        desc.rst   = col_chg && (r_prior_class != CLS_NONE);
        desc.col   = col_chg;
        desc.cls   = cls;
        desc.data  = b;
        desc.space = 1'b0;
        desc.body  = BK_HEX;
        unique case (r_mode)
            MODE_MIXED: begin
                desc.space = was_print && !is_print;
                priority if (b == CH_SPACE) desc.body = BK_UNDER;
                else if (r_prior_byte == CH_CR && b == CH_LF) desc.body = BK_HEXCRLF;
                else if (graphic) desc.body = BK_CHAR;
                else desc.body = BK_HEX;
            end
            MODE_TWO: begin
                priority if (b == CH_SPACE) desc.body = BK_UNDER2;
                else if (graphic) desc.body = BK_CHAR2;
                else desc.body = BK_HEX;
            end
            default: desc.body = BK_HEX;
        endcase
    end

    assign o_push.valid = accept;
    assign o_push.desc  = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_en    <= 1'b0;
            r_mode        <= MODE_HEX;
            r_prior_byte  <= 8'h00;
            r_prior_class <= CLS_NONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLOR: r_color_en <= i_cfg_data[0];
                    default:   r_mode     <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_prior_byte <= b;
                if (col_chg) begin
                    r_prior_class <= cls;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/hdf_queue.sv =====
`default_nettype none
module hdf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hdf_pkg::t_q_push i_push,
    input  wire logic             i_pop,
    output hdf_pkg::t_desc        o_desc,
    output hdf_pkg::t_q_stat      o_stat
);
    import hdf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_desc          = r_mem[r_rd_ptr];
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push.valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/hdf_back.sv =====
`default_nettype none
module hdf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hdf_pkg::t_desc   i_desc,
    input  wire hdf_pkg::t_q_stat i_stat,
    output logic                  o_pop,
    hdf_out_if.source             o_out
);
    import hdf_pkg::*;

    logic       r_busy;
    t_desc      r_cur;
    logic [1:0] r_seg;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       emit;
    logic       seg_end;
    logic       done_item;
    logic [7:0] n_char;

    always_comb begin
        emit      = r_busy && (!r_out_valid || o_out.ready);
        seg_end   = (r_idx == seg_len(r_cur, r_seg) - 3'd1);
        done_item = emit && (r_seg == SEG_BODY) && seg_end;
        n_char    = seg_byte(r_cur, r_seg, r_idx);
        o_pop     = i_stat.nonempty && (!r_busy || done_item);
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        if (emit) begin
            r_out_char <= n_char;
            r_out_last <= (r_seg == SEG_BODY) && seg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_seg       <= SEG_RST;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_seg  <= first_seg(i_desc, SEG_RST);
                r_idx  <= 3'd0;
            end else if (done_item) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                if (seg_end) begin
                    r_seg <= first_seg(r_cur, r_seg + 2'd1);
                    r_idx <= 3'd0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    import hdf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 150;

    typedef struct {
        logic [7:0] ch;
        logic       last_of_run;
    } t_exp_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [1:0] cfg_data;

    hdf_in_if  in_ch ();
    hdf_out_if out_ch ();

    hex_dump_byte_formatter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // bytes waiting to be offered, and characters still owed by the block
    logic [7:0] pending_bytes [$];
    t_exp_char  expected_chars [$];

    // formatter state as predicted
    logic       color_on;
    logic [1:0] mode_sel;
    logic [7:0] last_byte_seen;
    logic [2:0] color_shown;

    int  mismatches = 0;
    bit  idle_on = 1'b1;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  hold_left = 0;
    int  send_gap = 0;
    int  rx_gap = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_NUL) return CLS_WHITE;
        if (b > CH_SPACE && b < CH_DEL) return CLS_GREEN;
        if (b == CH_TAB || b == CH_LF || b == CH_CR) return CLS_YELLOW;
        if (b == CH_FF) return CLS_BLUE;
        return CLS_RED;
    endfunction

    function automatic logic [7:0] shade_digit(input logic [2:0] cls);
        case (cls)
            CLS_WHITE:  return "7";
            CLS_GREEN:  return "2";
            CLS_YELLOW: return "3";
            CLS_BLUE:   return "4";
            default:    return "1";
        endcase
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return 8'("a") + 8'(n) - 8'd10;
    endfunction

    function automatic bit text_byte(input logic [7:0] b);
        return b >= CH_SPACE && b < CH_DEL;
    endfunction

    task automatic emit_char(input logic [7:0] c);
        t_exp_char e;
        e.ch = c;
        e.last_of_run = 1'b0;
        expected_chars.push_back(e);
    endtask

    task automatic emit_hex(input logic [7:0] b);
        emit_char(hex_ascii(b[7:4]));
        emit_char(hex_ascii(b[3:0]));
        emit_char(CH_SPACE);
    endtask

    task automatic predict_format(input logic [7:0] b);
        logic       graphic;
        logic [2:0] cls;
        t_exp_char  e;
        graphic = b > CH_SPACE && b < CH_DEL;
        if (color_on) begin
            cls = byte_class(b);
            if (cls != color_shown) begin
                if (color_shown != CLS_NONE) begin
                    emit_char(CH_ESC);
                    emit_char(CH_LBR);
                    emit_char(CH_ZERO);
                    emit_char(CH_M);
                end
                emit_char(CH_ESC);
                emit_char(CH_LBR);
                emit_char(CH_THREE);
                emit_char(shade_digit(cls));
                emit_char(CH_M);
                color_shown = cls;
            end
        end
        case (mode_sel)
            MODE_MIXED: begin
                if (text_byte(last_byte_seen) && !text_byte(b)) emit_char(CH_SPACE);
                if (b == CH_SPACE) begin
                    emit_char(CH_UNDER);
                end else if (last_byte_seen == CH_CR && b == CH_LF) begin
                    emit_hex(b);
                    emit_char(CH_CR);
                    emit_char(CH_LF);
                end else if (graphic) begin
                    emit_char(b);
                end else begin
                    emit_hex(b);
                end
            end
            MODE_TWO: begin
                if (b == CH_SPACE) begin
                    emit_char(CH_UNDER);
                    emit_char(CH_UNDER);
                    emit_char(CH_SPACE);
                end else if (graphic) begin
                    emit_char(b);
                    emit_char(CH_SPACE);
                    emit_char(CH_SPACE);
                end else begin
                    emit_hex(b);
                end
            end
            default: emit_hex(b);
        endcase
        last_byte_seen = b;
        e = expected_chars.pop_back();
        e.last_of_run = 1'b1;
        expected_chars.push_back(e);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] gen_byte();
        logic [7:0] ctl [3];
        ctl = '{CH_TAB, CH_LF, CH_CR};
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(8'h21, 8'h7e));
            3:       return $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
            4:       return ctl[$urandom_range(0, 2)];
            5:       return CH_FF;
            6:       return 8'($urandom_range(8'h7f, 8'hfe));
            7:       return 8'($urandom_range(8'h01, 8'h1f));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sender
    always @(posedge i_clk) begin
        logic       nv;
        logic [7:0] nd;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= CH_NUL;
            send_gap = 0;
        end else begin
            nv = in_ch.valid;
            nd = in_ch.data_byte;
            if (in_ch.valid && in_ch.ready) begin
                predict_format(in_ch.data_byte);
                nv = 1'b0;
                send_gap = idle_on ? pick_gap() : 0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    nv = 1'b1;
                    nd = pending_bytes.pop_front();
                end
            end
            in_ch.valid     <= nv;
            in_ch.data_byte <= nd;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        logic      nr;
        t_exp_char e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
            rx_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output char %h last %b",
                                 out_ch.out_char, out_ch.last_of_run);
                end else begin
                    e = expected_chars.pop_front();
                    if (out_ch.out_char !== e.ch) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("out_char: expected %h, got %h", e.ch, out_ch.out_char);
                    end
                    if (out_ch.last_of_run !== e.last_of_run) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("last_of_run: expected %b, got %b (char %h)",
                                     e.last_of_run, out_ch.last_of_run, e.ch);
                    end
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
            end
            out_ch.ready <= nr;
        end
    end

    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COLOR) color_on = val[0];
        else mode_sel = val;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_chars.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int k;
        @(negedge i_clk);
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 7) == 0) begin
                pending_bytes.push_back(CH_CR);
                pending_bytes.push_back(CH_LF);
                k += 2;
            end else begin
                pending_bytes.push_back(gen_byte());
                k++;
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] color_val, input logic [1:0] mode_val,
                             input int n, input bit with_hold, input bit with_idle);
        write_reg(CFG_COLOR, color_val);
        write_reg(CFG_MODE, mode_val);
        @(negedge i_clk);
        idle_on = with_idle;
        if (with_hold) begin
            hold_req++;
            queue_random(n / 2);
            wait_drained();
            queue_random(n - n / 2);
        end else begin
            queue_random(n);
        end
        wait_drained();
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = CH_NUL;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_COLOR;
        cfg_data        = 2'd0;
        i_rst_n         = 1'b0;
        color_on        = 1'b0;
        mode_sel        = MODE_HEX;
        last_byte_seen  = CH_NUL;
        color_shown     = CLS_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: plain hex, no color
        @(negedge i_clk);
        pending_bytes = '{CH_NUL, CH_FF, CH_DEL};
        wait_drained();

        // color on via a value with the upper bit set, mixed mode
        write_reg(CFG_COLOR, 2'b11);
        write_reg(CFG_MODE, MODE_MIXED);
        @(negedge i_clk);
        pending_bytes = '{8'h41, CH_SPACE, CH_NUL, CH_CR, CH_LF, CH_LF, CH_TAB,
                          CH_FF, 8'h80, 8'hfe, 8'h7e, CH_DEL};
        wait_drained();

        write_reg(CFG_MODE, MODE_TWO);
        @(negedge i_clk);
        pending_bytes = '{CH_SPACE, 8'h21, 8'h7e, CH_NUL, 8'h1f};
        wait_drained();

        // unused mode acts as hex; color off with only the ignored bit set
        write_reg(CFG_COLOR, 2'b10);
        write_reg(CFG_MODE, MODE_UNUSED);
        @(negedge i_clk);
        pending_bytes = '{8'h55, 8'haa};
        wait_drained();

        run_phase(2'b01, MODE_MIXED, 24, 1'b1, 1'b1);
        run_phase(2'b00, MODE_TWO, 18, 1'b0, 1'b1);
        run_phase(2'b01, MODE_HEX, 18, 1'b0, 1'b0);
        run_phase(2'b11, MODE_TWO, 20, 1'b0, 1'b1);
        run_phase(2'b00, MODE_MIXED, 20, 1'b0, 1'b1);
        run_phase(2'b01, MODE_UNUSED, 16, 1'b0, 1'b1);
        run_phase(2'b10, MODE_HEX, 14, 1'b0, 1'b1);
        run_phase(2'b01, MODE_MIXED, 30, 1'b1, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
